// ===== rtl/owb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types, codes and defaults of the one-wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

  localparam int MAX_BITS_DEF      = 8;
  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_DATA_W-1:0] RESET_LOW_DEF    = 16'd480;
  localparam logic [CFG_DATA_W-1:0] SLOT_DEF         = 16'd75;
  localparam logic [CFG_DATA_W-1:0] SHORT_LOW_DEF    = 16'd1;
  localparam logic [CFG_DATA_W-1:0] LONG_LOW_DEF     = 16'd62;
  localparam logic [CFG_DATA_W-1:0] SAMPLE_DELAY_DEF = 16'd14;
  localparam logic [CFG_DATA_W-1:0] READ_IDLE_DEF    = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW    = 3'd0,
    REG_SLOT         = 3'd1,
    REG_SHORT_LOW    = 3'd2,
    REG_LONG_LOW     = 3'd3,
    REG_SAMPLE_DELAY = 3'd4,
    REG_READ_IDLE    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Command class as seen by the sequencer
  typedef enum logic [2:0] {
    CL_NONE  = 3'd0,
    CL_RESET = 3'd1,
    CL_WRITE = 3'd2,
    CL_READ  = 3'd3,
    CL_ZERO  = 3'd4,
    CL_BIG   = 3'd5
  } cls_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_RST_LOW    = 3'd1,
    PH_RST_WAIT   = 3'd2,
    PH_RST_SAMPLE = 3'd3,
    PH_SLOT_LOW   = 3'd4,
    PH_SLOT_REL   = 3'd5,
    PH_RD_SAMPLE  = 3'd6,
    PH_RD_IDLE    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] write_data;
    logic [3:0] bit_count;
    logic       line_level;
  } owb_in_t;

  typedef struct packed {
    cls_e       kind;
    logic [7:0] write_data;
    logic [3:0] bit_count;
    logic       line_level;
  } owb_cmd_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_bits;
    logic       status;
  } owb_res_t;

endpackage

// ===== rtl/owb_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_fifo
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module owb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/owb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_front
// Classify each incoming tick word for the bus sequencer.
// ----------------------------------------------------------------------------
module owb_front import owb_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  owb_in_t  item_i,
  output owb_cmd_t cmd_o
);

  logic too_many, zero_bits;

  assign too_many  = (item_i.bit_count > 4'(MAX_BITS));
  assign zero_bits = (item_i.bit_count == 4'd0);

  always_comb begin
    cmd_o.write_data = item_i.write_data;
    cmd_o.bit_count  = item_i.bit_count;
    cmd_o.line_level = item_i.line_level;
    case (cmd_e'(item_i.command))
      CMD_RESET: cmd_o.kind = CL_RESET;
      CMD_WRITE: cmd_o.kind = too_many ? CL_BIG : (zero_bits ? CL_ZERO : CL_WRITE);
      CMD_READ:  cmd_o.kind = too_many ? CL_BIG : (zero_bits ? CL_ZERO : CL_READ);
      default:   cmd_o.kind = CL_NONE;
    endcase
  end

endmodule

// ===== rtl/owb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_back
// Bus sequencer: runs reset, write and read slots one tick per word.
// ----------------------------------------------------------------------------
module owb_back import owb_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cmd_valid_i,
  input  owb_cmd_t              cmd_i,
  output logic                  cmd_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output owb_res_t              res_o
);

  localparam int CW = COUNTER_WIDTH;
  localparam logic [31:0] CMAX = 32'((64'd1 << CW) - 64'd1);

  function automatic logic [CW-1:0] clamp_len(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) w = 32'd1;
    if (w > CMAX) w = CMAX;
    return CW'(w);
  endfunction

  logic [CFG_DATA_W-1:0] rst_low_q, slot_q, short_q, long_q, sdel_q, ridle_q;

  phase_e      phase_q, phase_d, ph0;
  op_e         op_q, op_d, op0;
  logic [CW-1:0] cnt_q, cnt_d, cnt0, cnt_inc, len;
  logic [7:0]  shift_q, shift_d, shift0;
  logic [3:0]  bits_q, bits_d, bits0, bits_dec;
  logic [2:0]  idx_q, idx_d, idx0;
  logic [7:0]  acc_q, acc_d, acc0;
  logic        pflag_q, pflag_d, pflag0;

  logic        take, idle, start_rst, start_xfer, hit;
  logic        bit_end, last, finish;
  logic [CW-1:0] wlow, whigh;
  logic [31:0] whigh_w;

  assign take       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = take;
  assign res_push_o = take;
  assign idle       = (phase_q == PH_IDLE);
  assign start_rst  = idle && (cmd_i.kind == CL_RESET);
  assign start_xfer = idle && ((cmd_i.kind == CL_WRITE) || (cmd_i.kind == CL_READ));

  // State after a possible command start on this tick
  always_comb begin
    ph0    = phase_q;
    op0    = op_q;
    cnt0   = cnt_q;
    shift0 = shift_q;
    bits0  = bits_q;
    idx0   = idx_q;
    acc0   = acc_q;
    pflag0 = pflag_q;
    if (start_rst) begin
      ph0    = PH_RST_LOW;
      op0    = OP_RESET;
      cnt0   = '0;
      pflag0 = 1'b0;
    end else if (start_xfer) begin
      ph0    = PH_SLOT_LOW;
      op0    = (cmd_i.kind == CL_WRITE) ? OP_WRITE : OP_READ;
      cnt0   = '0;
      shift0 = cmd_i.write_data;
      bits0  = cmd_i.bit_count;
      idx0   = '0;
      acc0   = '0;
    end
  end

  assign wlow    = shift0[0] ? clamp_len(short_q) : clamp_len(long_q);
  assign whigh_w = (32'(slot_q) > 32'(wlow)) ? 32'(slot_q) - 32'(wlow) : 32'd0;
  assign whigh   = (whigh_w > CMAX) ? CW'(CMAX) : CW'(whigh_w);

  always_comb begin
    case (ph0)
      PH_RST_LOW:  len = clamp_len(rst_low_q);
      PH_RST_WAIT: len = clamp_len(slot_q);
      PH_SLOT_LOW: len = (op0 == OP_WRITE) ? wlow : clamp_len(short_q);
      PH_SLOT_REL: len = (op0 == OP_WRITE) ? whigh : clamp_len(sdel_q);
      PH_RD_IDLE:  len = clamp_len(ridle_q);
      default:     len = clamp_len(ridle_q);
    endcase
  end

  assign cnt_inc  = cnt0 + CW'(1);
  assign hit      = (cnt_inc >= len);
  assign bits_dec = bits0 - 4'd1;

  always_comb begin
    case (ph0)
      PH_SLOT_LOW: bit_end = (op0 == OP_WRITE) && hit && (whigh == '0);
      PH_SLOT_REL: bit_end = (op0 == OP_WRITE) && hit;
      PH_RD_IDLE:  bit_end = hit;
      default:     bit_end = 1'b0;
    endcase
  end

  assign last   = bit_end && (bits_dec == 4'd0);
  assign finish = (ph0 == PH_RST_SAMPLE) || last;

  // Next state
  always_comb begin
    phase_d = ph0;
    op_d    = op0;
    cnt_d   = cnt0;
    shift_d = shift0;
    bits_d  = bits0;
    idx_d   = idx0;
    acc_d   = acc0;
    pflag_d = pflag0;
    case (ph0)
      PH_RST_LOW: begin
        cnt_d = hit ? '0 : cnt_inc;
        if (hit) phase_d = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        cnt_d = hit ? '0 : cnt_inc;
        if (hit) phase_d = PH_RST_SAMPLE;
      end
      PH_RST_SAMPLE: begin
        pflag_d = ~cmd_i.line_level;
      end
      PH_SLOT_LOW: begin
        cnt_d = hit ? '0 : cnt_inc;
        if (hit && !bit_end) phase_d = PH_SLOT_REL;
      end
      PH_SLOT_REL: begin
        cnt_d = hit ? '0 : cnt_inc;
        if (hit && (op0 != OP_WRITE)) phase_d = PH_RD_SAMPLE;
      end
      PH_RD_SAMPLE: begin
        acc_d[idx0] = acc0[idx0] | cmd_i.line_level;
        phase_d     = PH_RD_IDLE;
        cnt_d       = '0;
      end
      PH_RD_IDLE: begin
        cnt_d = hit ? '0 : cnt_inc;
      end
      default: begin
        cnt_d = cnt0;
      end
    endcase
    if (bit_end) begin
      if (op0 == OP_WRITE) begin
        shift_d = {1'b0, shift0[7:1]};
      end else begin
        idx_d = idx0 + 3'd1;
      end
      bits_d = bits_dec;
      if (!last) begin
        phase_d = PH_SLOT_LOW;
        cnt_d   = '0;
      end
    end
    if (finish) begin
      phase_d = PH_IDLE;
      cnt_d   = '0;
      op_d    = OP_NONE;
    end
  end

  // Result word
  always_comb begin
    res_o.drive_low = (ph0 == PH_RST_LOW) || (ph0 == PH_SLOT_LOW);
    res_o.busy_res  = (ph0 != PH_IDLE) && !finish;
    res_o.done_res  = finish || (idle && ((cmd_i.kind == CL_ZERO) || (cmd_i.kind == CL_BIG)));
    res_o.presence  = finish && (op0 == OP_RESET) && ~cmd_i.line_level;
    res_o.rx_bits   = (finish && (op0 == OP_READ)) ? acc0 : 8'd0;
    res_o.status    = idle && (cmd_i.kind == CL_BIG);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q <= RESET_LOW_DEF;
      slot_q    <= SLOT_DEF;
      short_q   <= SHORT_LOW_DEF;
      long_q    <= LONG_LOW_DEF;
      sdel_q    <= SAMPLE_DELAY_DEF;
      ridle_q   <= READ_IDLE_DEF;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_RESET_LOW:    rst_low_q <= cfg_data_i;
        REG_SLOT:         slot_q    <= cfg_data_i;
        REG_SHORT_LOW:    short_q   <= cfg_data_i;
        REG_LONG_LOW:     long_q    <= cfg_data_i;
        REG_SAMPLE_DELAY: sdel_q    <= cfg_data_i;
        REG_READ_IDLE:    ridle_q   <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= OP_NONE;
      cnt_q   <= '0;
      shift_q <= '0;
      bits_q  <= '0;
      idx_q   <= '0;
      acc_q   <= '0;
      pflag_q <= 1'b0;
    end else if (take) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      pflag_q <= pflag_d;
    end
  end

endmodule

// ===== rtl/one_wire_bus_master.sv =====
`timescale 1ns / 1ps
// A tick word is registered in the command queue, its result word in the result queue.
// Throughput: one tick word per cycle, stalled while the result queue is full.
// The command queue and the result queue are two words deep each.
// Reset: queues empty, sequencer idle, timing registers back to their defaults.
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master: tick classifier, command queue, sequencer, result queue.
// ----------------------------------------------------------------------------
module one_wire_bus_master import owb_pkg::*; #(
  parameter int MAX_BITS      = MAX_BITS_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  owb_in_t               in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output owb_res_t              out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CMD_W = $bits(owb_cmd_t);
  localparam int RES_W = $bits(owb_res_t);

  owb_cmd_t cmd_in, cmd_out;
  owb_res_t res_in;
  logic     cmd_empty, cmd_pop, res_full, res_push;
  logic [CMD_W-1:0] cmd_q_data;
  logic [RES_W-1:0] res_q_data;

  assign cfg_ready_o = 1'b1;

  owb_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .item_i (in_item_i),
    .cmd_o  (cmd_in)
  );

  owb_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_q_data),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  assign cmd_out = owb_cmd_t'(cmd_q_data);

  owb_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  owb_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_q_data),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign out_item_o = owb_res_t'(res_q_data);

endmodule
